[rtl/erce_pkg.sv]
// Shared types and constants of the eager ring credit endpoint.
// Item and result layouts, handshake phase, status codes, controller states.
// No dependencies.
package erce_pkg;

    localparam int KIND_W   = 2;
    localparam int LEN_W    = 16;
    localparam int GEN_W    = 32;
    localparam int CNT_W    = 64;
    localparam int RSLOT_W  = 17;
    localparam int BYTES_W  = 16;
    localparam int OFF_W    = 32;
    localparam int SIDX_W   = 16;
    localparam int STATUS_W = 2;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE      = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RING_SLOTS  = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_BYTES  = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAYLOAD_MAX = 8'd3;

    localparam logic [RSLOT_W-1:0] RING_SLOTS_RST  = 17'd16;
    localparam logic [BYTES_W-1:0] SLOT_BYTES_RST  = 16'd1024;
    localparam logic [LEN_W-1:0]   PAYLOAD_MAX_RST = 16'd992;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEND   = 2'd0,
        KIND_CHECK  = 2'd1,
        KIND_CREDIT = 2'd2,
        KIND_CTRL   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ACCEPTED = 2'd0,
        STAT_FALLBACK = 2'd1,
        STAT_RETRY    = 2'd2,
        STAT_IGNORED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PHASE_NONE  = 2'd0,
        PHASE_CONN  = 2'd1,
        PHASE_READY = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CTL_IDLE = 2'd0,
        CTL_EXEC = 2'd1,
        CTL_DIV  = 2'd2
    } ctl_state_t;

    typedef struct packed {
        kind_t              kind;
        logic [LEN_W-1:0]   length;
        logic               post_ok;
        logic [GEN_W-1:0]   observed_gen;
        logic [CNT_W-1:0]   counter_value;
        logic               ctrl_is_request;
        logic [RSLOT_W-1:0] remote_slots;
        logic [BYTES_W-1:0] remote_slot_bytes;
        logic               info_valid;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [SIDX_W-1:0]  slot_index;
        logic [GEN_W-1:0]   slot_gen;
        logic [OFF_W-1:0]   remote_offset;
        logic [CNT_W-1:0]   piggyback_ack;
        logic               send_ring_request;
        logic               send_ring_ack;
        logic               deliver;
        logic               credit_return;
        logic [CNT_W-1:0]   credit_out;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic cap_item;
        logic exec_fire;
        logic div_start;
        logic div_tx;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rx_pending;
        logic out_free;
        logic adopt;
        logic div_done;
        logic div_active;
    } ctl_stat_t;

endpackage

[rtl/erce_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Gives the low quotient bits and the remainder; no package dependency.
module erce_div #(
    parameter int DIV_W = 17,
    parameter int DVD_W = 64,
    parameter int QUO_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             active,
    output logic             done,
    output logic [QUO_W-1:0] quotient,
    output logic [DIV_W-1:0] remainder
);

    localparam int CNT_BITS = $clog2(DVD_W);
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(DVD_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [DIV_W-1:0]    dsr_reg, dsr_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [DIV_W:0]      part;
    logic                ge;

    assign part = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge   = part >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = ge ? DIV_W'(part - {1'b0, dsr_reg}) : part[DIV_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign active    = busy_reg | done_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/erce_datapath.sv]
// Datapath: configuration registers, ring counters, item evaluation, output register.
// Depends on erce_pkg and erce_div.
module erce_datapath #(
    parameter int MAX_SLOTS = 65536
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [erce_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [erce_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  erce_pkg::item_t                     item_in,
    input  erce_pkg::ctl_cmd_t                  cmd,
    output erce_pkg::ctl_stat_t                 stat,
    input  logic                                m_tready,
    output logic                                out_valid,
    output erce_pkg::result_t                   result
);

    localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int CW     = erce_pkg::CNT_W;
    localparam int GW     = erce_pkg::GEN_W;
    localparam int OW     = erce_pkg::OFF_W;
    localparam int SW     = erce_pkg::SIDX_W;
    localparam int RW     = erce_pkg::RSLOT_W;
    localparam logic [SLOT_W-1:0] RX_SLOTS_RST =
        (MAX_SLOTS < 16) ? SLOT_W'(MAX_SLOTS) : SLOT_W'(16);

    function automatic logic [SLOT_W-1:0] eff_slots(input logic [RW-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == '0) begin
            r = SLOT_W'(1);
        end else if (32'(s) > 32'(MAX_SLOTS)) begin
            r = SLOT_W'(MAX_SLOTS);
        end else begin
            r = SLOT_W'(s);
        end
        return r;
    endfunction

    // configuration
    logic                          enable_reg;
    logic [RW-1:0]                 ring_slots_reg;
    logic [erce_pkg::BYTES_W-1:0]  slot_bytes_reg;
    logic [erce_pkg::LEN_W-1:0]    payload_max_reg;
    logic [SLOT_W-1:0]             rx_slots_reg;
    logic                          rx_pending_reg, rx_pending_next;

    // ring state
    erce_pkg::item_t               item_reg;
    erce_pkg::phase_t              phase_reg, phase_next;
    logic [CW-1:0]                 tx_head_reg, tx_head_next;
    logic [CW-1:0]                 tx_tail_reg, tx_tail_next;
    logic [CW-1:0]                 rx_head_reg, rx_head_next;
    logic [CW-1:0]                 gap_reg, gap_next;
    logic [IDX_W-1:0]              tx_idx_reg, tx_idx_next;
    logic [GW-1:0]                 tx_gen_reg, tx_gen_next;
    logic [IDX_W-1:0]              rx_idx_reg, rx_idx_next;
    logic [GW-1:0]                 rx_gen_reg, rx_gen_next;
    logic [SLOT_W-1:0]             adopted_slots_reg, adopted_slots_next;
    logic [erce_pkg::BYTES_W-1:0]  adopted_bytes_reg, adopted_bytes_next;
    logic                          div_tx_reg;
    logic                          out_valid_reg, out_valid_next;
    erce_pkg::result_t             res_reg, res_next;

    // evaluation terms
    logic                          tail_raise;
    logic [CW-1:0]                 diff;
    logic                          full;
    logic                          tx_wrap, rx_wrap;
    logic [CW-1:0]                 rx_head_inc;
    logic [SLOT_W-1:0]             half, half_m1;
    logic                          credit_due;
    logic [OW-1:0]                 offset_prod;
    logic                          geom_match;
    logic                          adopt;

    // divider
    logic [CW-1:0]                 div_dividend;
    logic [SLOT_W-1:0]             div_divisor;
    logic                          div_active, div_done;
    logic [GW-1:0]                 div_quo;
    logic [SLOT_W-1:0]             div_rem;

    assign tail_raise  = item_reg.counter_value > tx_tail_reg;
    assign diff        = tail_raise ? (tx_head_reg - item_reg.counter_value)
                                    : (tx_head_reg - tx_tail_reg);
    assign full        = diff >= CW'(adopted_slots_reg);
    assign tx_wrap     = ((SLOT_W+1)'(tx_idx_reg) + (SLOT_W+1)'(1))
                         == (SLOT_W+1)'(adopted_slots_reg);
    assign rx_wrap     = ((SLOT_W+1)'(rx_idx_reg) + (SLOT_W+1)'(1))
                         == (SLOT_W+1)'(rx_slots_reg);
    assign rx_head_inc = rx_head_reg + CW'(1);
    assign half        = rx_slots_reg >> 1;
    assign half_m1     = half - SLOT_W'(1);
    // gap is rx_head minus credit sent; test gap + 1 >= half without a second adder
    assign credit_due  = (half == '0) || ((gap_reg != '1) && (gap_reg >= CW'(half_m1)));
    assign offset_prod = OW'(32'(tx_idx_reg) * 32'(adopted_bytes_reg));
    assign geom_match  = (item_reg.remote_slots == ring_slots_reg) &&
                         (item_reg.remote_slot_bytes == slot_bytes_reg);
    assign adopt       = (item_reg.kind == erce_pkg::KIND_CTRL) && enable_reg &&
                         item_reg.info_valid && geom_match;

    always_comb begin
        phase_next         = phase_reg;
        tx_head_next       = tx_head_reg;
        tx_tail_next       = tx_tail_reg;
        rx_head_next       = rx_head_reg;
        gap_next           = gap_reg;
        tx_idx_next        = tx_idx_reg;
        tx_gen_next        = tx_gen_reg;
        rx_idx_next        = rx_idx_reg;
        rx_gen_next        = rx_gen_reg;
        adopted_slots_next = adopted_slots_reg;
        adopted_bytes_next = adopted_bytes_reg;
        res_next           = '0;
        res_next.status    = erce_pkg::STAT_IGNORED;
        case (item_reg.kind)
            erce_pkg::KIND_SEND: begin
                if (!enable_reg || (item_reg.length > payload_max_reg)) begin
                    res_next.status = erce_pkg::STAT_FALLBACK;
                end else if (phase_reg != erce_pkg::PHASE_READY) begin
                    if (phase_reg == erce_pkg::PHASE_NONE) begin
                        res_next.send_ring_request = 1'b1;
                        phase_next = erce_pkg::PHASE_CONN;
                    end
                    res_next.status = erce_pkg::STAT_FALLBACK;
                end else begin
                    if (tail_raise) begin
                        tx_tail_next = item_reg.counter_value;
                    end
                    if (full || !item_reg.post_ok) begin
                        res_next.status = erce_pkg::STAT_RETRY;
                    end else begin
                        res_next.status        = erce_pkg::STAT_ACCEPTED;
                        res_next.slot_index    = SW'(tx_idx_reg);
                        res_next.slot_gen      = tx_gen_reg;
                        res_next.remote_offset = offset_prod;
                        res_next.piggyback_ack = rx_head_reg;
                        tx_head_next           = tx_head_reg + CW'(1);
                        tx_idx_next = tx_wrap ? '0 : tx_idx_reg + IDX_W'(1);
                        tx_gen_next = tx_wrap ? tx_gen_reg + GW'(1) : tx_gen_reg;
                    end
                end
            end
            erce_pkg::KIND_CHECK: begin
                if (enable_reg && (phase_reg == erce_pkg::PHASE_READY) &&
                    (item_reg.observed_gen == rx_gen_reg)) begin
                    if (tail_raise) begin
                        tx_tail_next = item_reg.counter_value;
                    end
                    res_next.status  = erce_pkg::STAT_ACCEPTED;
                    res_next.deliver = 1'b1;
                    rx_head_next     = rx_head_inc;
                    rx_idx_next = rx_wrap ? '0 : rx_idx_reg + IDX_W'(1);
                    rx_gen_next = rx_wrap ? rx_gen_reg + GW'(1) : rx_gen_reg;
                    if (credit_due && item_reg.post_ok) begin
                        res_next.credit_return = 1'b1;
                        res_next.credit_out    = rx_head_inc;
                        gap_next               = '0;
                    end else begin
                        gap_next = gap_reg + CW'(1);
                    end
                end
            end
            erce_pkg::KIND_CREDIT: begin
                if (enable_reg) begin
                    if (tail_raise) begin
                        tx_tail_next = item_reg.counter_value;
                    end
                    res_next.status = erce_pkg::STAT_ACCEPTED;
                end
            end
            erce_pkg::KIND_CTRL: begin
                if (enable_reg && item_reg.info_valid) begin
                    if (!geom_match) begin
                        res_next.status = erce_pkg::STAT_FALLBACK;
                    end else begin
                        adopted_slots_next     = eff_slots(item_reg.remote_slots);
                        adopted_bytes_next     = item_reg.remote_slot_bytes;
                        res_next.send_ring_ack = item_reg.ctrl_is_request;
                        phase_next             = erce_pkg::PHASE_READY;
                        res_next.status        = erce_pkg::STAT_ACCEPTED;
                    end
                end
            end
            default: begin
                res_next.status = erce_pkg::STAT_IGNORED;
            end
        endcase
    end

    // resync target: tx index after an adopt, rx index after a slot count write
    assign div_dividend = cmd.div_tx ? tx_head_reg : rx_head_reg;
    assign div_divisor  = cmd.div_tx ? eff_slots(item_reg.remote_slots) : rx_slots_reg;

    erce_div #(
        .DIV_W (SLOT_W),
        .DVD_W (CW),
        .QUO_W (GW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .active    (div_active),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        rx_pending_next = rx_pending_reg;
        if (cmd.div_start && !cmd.div_tx) begin
            rx_pending_next = 1'b0;
        end
        if (cfg_we && (cfg_addr == erce_pkg::CFG_RING_SLOTS)) begin
            rx_pending_next = 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.exec_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg        <= 1'b0;
            ring_slots_reg    <= erce_pkg::RING_SLOTS_RST;
            slot_bytes_reg    <= erce_pkg::SLOT_BYTES_RST;
            payload_max_reg   <= erce_pkg::PAYLOAD_MAX_RST;
            rx_slots_reg      <= RX_SLOTS_RST;
            rx_pending_reg    <= 1'b0;
            phase_reg         <= erce_pkg::PHASE_NONE;
            tx_head_reg       <= '0;
            tx_tail_reg       <= '0;
            rx_head_reg       <= '0;
            gap_reg           <= '0;
            tx_idx_reg        <= '0;
            tx_gen_reg        <= GW'(1);
            rx_idx_reg        <= '0;
            rx_gen_reg        <= GW'(1);
            adopted_slots_reg <= SLOT_W'(1);
            adopted_bytes_reg <= '0;
            div_tx_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            rx_pending_reg <= rx_pending_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    erce_pkg::CFG_ENABLE:      enable_reg <= cfg_data[0];
                    erce_pkg::CFG_RING_SLOTS: begin
                        ring_slots_reg <= cfg_data[RW-1:0];
                        rx_slots_reg   <= eff_slots(cfg_data[RW-1:0]);
                    end
                    erce_pkg::CFG_SLOT_BYTES:  slot_bytes_reg  <= cfg_data[15:0];
                    erce_pkg::CFG_PAYLOAD_MAX: payload_max_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (cmd.div_start) begin
                div_tx_reg <= cmd.div_tx;
            end
            if (cmd.exec_fire) begin
                phase_reg         <= phase_next;
                tx_head_reg       <= tx_head_next;
                tx_tail_reg       <= tx_tail_next;
                rx_head_reg       <= rx_head_next;
                gap_reg           <= gap_next;
                tx_idx_reg        <= tx_idx_next;
                tx_gen_reg        <= tx_gen_next;
                rx_idx_reg        <= rx_idx_next;
                rx_gen_reg        <= rx_gen_next;
                adopted_slots_reg <= adopted_slots_next;
                adopted_bytes_reg <= adopted_bytes_next;
            end else if (div_done) begin
                if (div_tx_reg) begin
                    tx_idx_reg <= IDX_W'(div_rem);
                    tx_gen_reg <= div_quo + GW'(1);
                end else begin
                    rx_idx_reg <= IDX_W'(div_rem);
                    rx_gen_reg <= div_quo + GW'(1);
                end
            end
        end
        if (cmd.cap_item) begin
            item_reg <= item_in;
        end
        if (cmd.exec_fire) begin
            res_reg <= res_next;
        end
    end

    assign stat.rx_pending = rx_pending_reg;
    assign stat.out_free   = !out_valid_reg || m_tready;
    assign stat.adopt      = adopt;
    assign stat.div_done   = div_done;
    assign stat.div_active = div_active;

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    a_tx_idx_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        !div_active |-> (SLOT_W'(tx_idx_reg) < adopted_slots_reg))
        else $error("tx slot index outside adopted ring");

    a_rx_idx_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (!div_active && !rx_pending_reg) |-> (SLOT_W'(rx_idx_reg) < rx_slots_reg))
        else $error("rx slot index outside local ring");

    a_exec_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec_fire |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before transfer");

    a_exec_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec_fire |=> out_valid_reg)
        else $error("evaluated item produced no result");

endmodule

[rtl/erce_ctrl.sv]
// Controller state machine: item capture, evaluation and divider resync sequencing.
// Depends on erce_pkg.
module erce_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  erce_pkg::ctl_stat_t   stat,
    output erce_pkg::ctl_cmd_t    cmd
);

    erce_pkg::ctl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            erce_pkg::CTL_IDLE: begin
                if (stat.rx_pending) begin
                    state_next = erce_pkg::CTL_DIV;
                end else if (s_tvalid) begin
                    state_next = erce_pkg::CTL_EXEC;
                end
            end
            erce_pkg::CTL_EXEC: begin
                if (stat.out_free) begin
                    state_next = stat.adopt ? erce_pkg::CTL_DIV : erce_pkg::CTL_IDLE;
                end
            end
            erce_pkg::CTL_DIV: begin
                if (stat.div_done) begin
                    state_next = erce_pkg::CTL_IDLE;
                end
            end
            default: state_next = erce_pkg::CTL_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        cmd.cap_item  = 1'b0;
        cmd.exec_fire = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_tx    = 1'b0;
        case (state_reg)
            erce_pkg::CTL_IDLE: begin
                s_tready      = !stat.rx_pending;
                cmd.cap_item  = s_tvalid && !stat.rx_pending;
                cmd.div_start = stat.rx_pending;
            end
            erce_pkg::CTL_EXEC: begin
                cmd.exec_fire = stat.out_free;
                cmd.div_start = stat.out_free && stat.adopt;
                cmd.div_tx    = 1'b1;
            end
            erce_pkg::CTL_DIV: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= erce_pkg::CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !stat.div_active)
        else $error("divider restarted while busy");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> (state_reg == erce_pkg::CTL_DIV))
        else $error("divider finished outside resync");

    a_capture_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cap_item |=> (state_reg == erce_pkg::CTL_EXEC))
        else $error("captured item not evaluated");

endmodule

[rtl/eager_ring_credit_endpoint.sv]
// Top level of the eager ring credit endpoint: stream ports and channel packing.
// Depends on erce_pkg, erce_ctrl, erce_datapath (which holds erce_div).
//
// One peer's end of an eager remote-write ring. Each input transfer (send request,
// slot check, credit update or control message, selected by s_axis_tuser) yields
// exactly one result transfer. An item is first taken into the input register,
// then evaluated against the ring counters into the output register once that
// is free; the next item is taken while a result still waits on m_axis_tready.
// The slot index and generation stamp are kept as wrap counters. Two events
// rebuild them from the 64-bit heads through a serial divider that retires one
// quotient bit a cycle: a control message that adopts the ring (tx side) and a
// write to ring_slots (rx side). During each rebuild s_axis_tready stays low;
// configuration writes are taken at all times (cfg_ready is tied high).
// Configuration is expected only while no item is in flight.
module eager_ring_credit_endpoint #(
    parameter int MAX_SLOTS = 65536
) (
    input  logic         aclk,
    input  logic         aresetn,

    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_addr,   // register index
    input  logic [31:0]  cfg_data,

    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // length[15:0], post_ok[16], observed_gen[48:17], counter_value[112:49],
    // ctrl_is_request[113], remote_slots[130:114], remote_slot_bytes[146:131],
    // info_valid[147], zero fill[151:148]
    input  logic [151:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]   s_axis_tuser,

    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // slot_index[15:0], slot_gen[47:16], remote_offset[79:48],
    // piggyback_ack[143:80], send_ring_request[144], send_ring_ack[145],
    // deliver[146], credit_return[147], credit_out[211:148], zero fill[215:212]
    output logic [215:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser
);

    erce_pkg::item_t     item;
    erce_pkg::result_t   res;
    erce_pkg::ctl_cmd_t  cmd;
    erce_pkg::ctl_stat_t stat;

    // never stall configuration
    assign cfg_ready = 1'b1;

    // unpack the input transfer
    assign item.kind              = erce_pkg::kind_t'(s_axis_tuser);
    assign item.length            = s_axis_tdata[15:0];
    assign item.post_ok           = s_axis_tdata[16];
    assign item.observed_gen      = s_axis_tdata[48:17];
    assign item.counter_value     = s_axis_tdata[112:49];
    assign item.ctrl_is_request   = s_axis_tdata[113];
    assign item.remote_slots      = s_axis_tdata[130:114];
    assign item.remote_slot_bytes = s_axis_tdata[146:131];
    assign item.info_valid        = s_axis_tdata[147];

    erce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    erce_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .item_in   (item),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .result    (res)
    );

    // pack the result transfer, highest field first
    assign m_axis_tdata = {4'b0000,
                           res.credit_out,
                           res.credit_return,
                           res.deliver,
                           res.send_ring_ack,
                           res.send_ring_request,
                           res.piggyback_ack,
                           res.remote_offset,
                           res.slot_gen,
                           res.slot_index};
    assign m_axis_tuser = res.status;

endmodule

[test/tb_eager_ring_credit_endpoint.sv]
// Self-checking testbench for eager_ring_credit_endpoint: directed and random ring traffic,
// with each result transfer checked field by field against a cycle-free ring predictor.
// Depends on erce_pkg and the eager_ring_credit_endpoint RTL.
`timescale 1ns / 100ps

module tb_eager_ring_credit_endpoint;
    import erce_pkg::*;

    localparam int MAX_SLOTS   = 65536;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 100;   // covers the counter rebuild

    // Predictor copy of everything the block keeps between items.
    typedef struct {
        logic        ring_on;
        logic [16:0] lcl_slots;
        logic [15:0] lcl_bytes;
        logic [15:0] len_cap;
        phase_t      phase;
        logic [63:0] tx_head;
        logic [63:0] tx_tail;
        logic [63:0] rx_head;
        logic [63:0] rx_credited;
        logic [16:0] peer_slots;
        logic [15:0] peer_bytes;
    } ring_shadow_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_addr = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [215:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    // shadow_plan runs ahead as items are queued so that the generator can
    // build well-formed sequences; shadow_live advances on each accepted transfer.
    ring_shadow_t shadow_plan;
    ring_shadow_t shadow_live;
    item_t        items_to_offer[$];
    result_t      results_due[$];
    logic         offer_live = 1'b0;
    int unsigned  tx_idle_pct = 37;
    int unsigned  rx_idle_pct = 86;
    logic         long_hold_req = 1'b0;
    logic         long_hold_done = 1'b0;
    int unsigned  stall_left = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;

    eager_ring_credit_endpoint #(
        .MAX_SLOTS(MAX_SLOTS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Clamp a slot count: zero acts as one ring slot, anything past the
    // maximum acts as the maximum.
    function automatic logic [16:0] fit_slots(input logic [16:0] s);
        if (s == 17'd0) begin
            return 17'd1;
        end
        if (s > 17'(MAX_SLOTS)) begin
            return 17'(MAX_SLOTS);
        end
        return s;
    endfunction

    // Work out the result of one item and advance the ring state.
    function automatic result_t eval_ring_item(inout ring_shadow_t st, input item_t it);
        result_t     r;
        logic [63:0] idx;
        logic [63:0] gen;
        logic [63:0] off;
        logic [63:0] want;
        logic [16:0] ls;
        r = '0;
        r.status = STAT_ACCEPTED;
        case (it.kind)
            KIND_SEND: begin
                if (!st.ring_on || it.length > st.len_cap) begin
                    r.status = STAT_FALLBACK;
                end else if (st.phase != PHASE_READY) begin
                    // ask for the ring only once, on the first refused send
                    if (st.phase == PHASE_NONE) begin
                        r.send_ring_request = 1'b1;
                        st.phase = PHASE_CONN;
                    end
                    r.status = STAT_FALLBACK;
                end else begin
                    // refresh the tail from the credit cell before the full test
                    if (it.counter_value > st.tx_tail) begin
                        st.tx_tail = it.counter_value;
                    end
                    if (st.tx_head - st.tx_tail >= 64'(st.peer_slots) || !it.post_ok) begin
                        r.status = STAT_RETRY;
                    end else begin
                        idx = st.tx_head % st.peer_slots;
                        gen = st.tx_head / st.peer_slots + 64'd1;
                        off = idx * st.peer_bytes;
                        r.slot_index    = idx[15:0];
                        r.slot_gen      = gen[31:0];
                        r.remote_offset = off[31:0];
                        r.piggyback_ack = st.rx_head;
                        st.tx_head = st.tx_head + 64'd1;
                    end
                end
            end
            KIND_CHECK: begin
                ls   = fit_slots(st.lcl_slots);
                want = st.rx_head / ls + 64'd1;
                if (!st.ring_on || st.phase != PHASE_READY || it.observed_gen != want[31:0]) begin
                    r.status = STAT_IGNORED;
                end else begin
                    if (it.counter_value > st.tx_tail) begin
                        st.tx_tail = it.counter_value;
                    end
                    r.deliver = 1'b1;
                    st.rx_head = st.rx_head + 64'd1;
                    // return credit once half a ring has drained since the last return
                    if (st.rx_head - st.rx_credited >= 64'(ls >> 1) && it.post_ok) begin
                        r.credit_return = 1'b1;
                        r.credit_out    = st.rx_head;
                        st.rx_credited  = st.rx_head;
                    end
                end
            end
            KIND_CREDIT: begin
                if (!st.ring_on) begin
                    r.status = STAT_IGNORED;
                end else if (it.counter_value > st.tx_tail) begin
                    st.tx_tail = it.counter_value;
                end
            end
            KIND_CTRL: begin
                if (!st.ring_on || !it.info_valid) begin
                    r.status = STAT_IGNORED;
                end else if (it.remote_slots != st.lcl_slots
                             || it.remote_slot_bytes != st.lcl_bytes) begin
                    r.status = STAT_FALLBACK;
                end else begin
                    st.peer_slots = fit_slots(it.remote_slots);
                    st.peer_bytes = it.remote_slot_bytes;
                    r.send_ring_ack = it.ctrl_is_request;
                    st.phase = PHASE_READY;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void apply_register(inout ring_shadow_t st,
                                           input logic [CFG_ADDR_W-1:0] addr,
                                           input logic [CFG_DATA_W-1:0] data);
        case (addr)
            CFG_ENABLE:      st.ring_on   = data[0];
            CFG_RING_SLOTS:  st.lcl_slots = data[16:0];
            CFG_SLOT_BYTES:  st.lcl_bytes = data[15:0];
            CFG_PAYLOAD_MAX: st.len_cap   = data[15:0];
            default: ;
        endcase
    endfunction

    // Plan an item ahead of time and hand it to the driver.
    function automatic status_t queue_item(input item_t it);
        result_t r;
        r = eval_ring_item(shadow_plan, it);
        items_to_offer.push_back(it);
        return r.status;
    endfunction

    function automatic item_t blank_item(input kind_t k);
        item_t b;
        b = '0;
        b.kind = k;
        return b;
    endfunction

    // Mostly well-formed traffic built from the planned ring state: credit
    // values never run past the head, slot checks mostly carry the expected
    // stamp, control messages mostly match the local geometry. The rest is
    // noise that cannot raise the tail beyond the head.
    function automatic item_t random_ring_item();
        item_t       it;
        logic [63:0] lag;
        logic [63:0] want;
        logic [63:0] credit;
        int unsigned span;
        int unsigned pick;
        it.kind              = kind_t'($urandom_range(0, 3));
        it.length            = 16'($urandom);
        it.post_ok           = 1'($urandom);
        it.observed_gen      = $urandom;
        it.counter_value     = {$urandom, $urandom};
        it.ctrl_is_request   = 1'($urandom);
        it.remote_slots      = 17'($urandom_range(0, 65536));
        it.remote_slot_bytes = 16'($urandom);
        it.info_valid        = 1'($urandom);
        lag  = shadow_plan.tx_head - shadow_plan.tx_tail;
        span = (lag <= 64'd65536) ? int'(lag) : 0;
        want = shadow_plan.rx_head / fit_slots(shadow_plan.lcl_slots) + 64'd1;
        credit = shadow_plan.tx_tail;
        if ($urandom_range(0, 1) != 0) begin
            credit = credit + 64'($urandom_range(0, span));
        end
        pick = $urandom_range(0, 99);
        if (pick < 34) begin
            it.kind          = KIND_SEND;
            it.counter_value = credit;
            it.post_ok       = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 9) != 0) begin
                it.length = 16'($urandom_range(0, shadow_plan.len_cap));
            end
        end else if (pick < 64) begin
            it.kind          = KIND_CHECK;
            it.counter_value = credit;
            it.post_ok       = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 99) < 85) begin
                it.observed_gen = want[31:0];
            end
        end else if (pick < 76) begin
            it.kind          = KIND_CREDIT;
            it.counter_value = credit;
        end else if (pick < 88) begin
            it.kind              = KIND_CTRL;
            it.info_valid        = ($urandom_range(0, 9) != 0);
            it.remote_slots      = (shadow_plan.lcl_slots > 17'(MAX_SLOTS))
                                   ? 17'(MAX_SLOTS) : shadow_plan.lcl_slots;
            it.remote_slot_bytes = shadow_plan.lcl_bytes;
            if ($urandom_range(0, 99) < 15) begin
                it.remote_slot_bytes = it.remote_slot_bytes ^ 16'($urandom_range(1, 65535));
            end
        end else if (it.kind == KIND_CHECK) begin
            // a stale stamp keeps the random credit value from being taken
            if (it.observed_gen == want[31:0]) begin
                it.observed_gen[0] = ~it.observed_gen[0];
            end
        end else begin
            it.counter_value = shadow_plan.tx_tail >> $urandom_range(0, 63);
        end
        return it;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            // cap the report so a broken build cannot flood the log
            if (mismatch_count <= 100) begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        end
    endfunction

    task automatic wait_drained();
        while (items_to_offer.size() != 0 || offer_live || results_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) begin
            @(posedge aclk);
        end
        apply_register(shadow_plan, addr, data);
        apply_register(shadow_live, addr, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_random(input int unsigned count);
        int unsigned n;
        n = 0;
        while (n < count) begin
            if (queue_item(random_ring_item()) != STAT_IGNORED) begin
                n++;
            end
        end
    endtask

    // One configuration setting: drain, reprogram every register, then
    // send two batches with a full drain between them.
    task automatic run_phase(input logic en, input logic [16:0] slots,
                             input logic [15:0] bytes, input logic [15:0] cap,
                             input int unsigned tx_pct, input int unsigned rx_pct,
                             input int unsigned count, input logic hold_rx);
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_register(CFG_ENABLE, 32'(en));
        write_register(CFG_RING_SLOTS, 32'(slots));
        write_register(CFG_SLOT_BYTES, 32'(bytes));
        write_register(CFG_PAYLOAD_MAX, 32'(cap));
        if (hold_rx) begin
            long_hold_req = 1'b1;
        end
        fill_random(count / 2);
        wait_drained();
        fill_random(count - count / 2);
    endtask

    // Input driver: present the head of the queue at the falling edge and
    // hold it until the transfer completes.
    always @(negedge aclk) begin
        if (!offer_live) begin
            if (aresetn && items_to_offer.size() != 0
                && $urandom_range(0, 99) >= tx_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= items_to_offer[0].kind;
                s_axis_tdata  <= {4'd0, items_to_offer[0].info_valid,
                                  items_to_offer[0].remote_slot_bytes,
                                  items_to_offer[0].remote_slots,
                                  items_to_offer[0].ctrl_is_request,
                                  items_to_offer[0].counter_value,
                                  items_to_offer[0].observed_gen,
                                  items_to_offer[0].post_ok,
                                  items_to_offer[0].length};
                offer_live = 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Take accepted items into the live predictor.
    always @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            results_due.push_back(eval_ring_item(shadow_live, items_to_offer.pop_front()));
            offer_live = 1'b0;
        end
    end

    // Result receiver: random back-pressure, plus one long hold-off once a
    // result is waiting so the block fills up and stalls its input.
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (long_hold_req && !long_hold_done && m_axis_tvalid === 1'b1) begin
            stall_left = 300;
            long_hold_done = 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Check each result transfer against the oldest expectation.
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: result expected none, got status %0d", $time, m_axis_tuser);
            end else begin
                want = results_due.pop_front();
                compare_field("status", 64'(want.status), 64'(m_axis_tuser));
                compare_field("slot_index", 64'(want.slot_index), 64'(m_axis_tdata[15:0]));
                compare_field("slot_gen", 64'(want.slot_gen), 64'(m_axis_tdata[47:16]));
                compare_field("remote_offset", 64'(want.remote_offset),
                              64'(m_axis_tdata[79:48]));
                compare_field("piggyback_ack", want.piggyback_ack, m_axis_tdata[143:80]);
                compare_field("send_ring_request", 64'(want.send_ring_request),
                              64'(m_axis_tdata[144]));
                compare_field("send_ring_ack", 64'(want.send_ring_ack), 64'(m_axis_tdata[145]));
                compare_field("deliver", 64'(want.deliver), 64'(m_axis_tdata[146]));
                compare_field("credit_return", 64'(want.credit_return), 64'(m_axis_tdata[147]));
                compare_field("credit_out", want.credit_out, m_axis_tdata[211:148]);
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        item_t d;
        shadow_plan.ring_on     = 1'b0;
        shadow_plan.lcl_slots   = RING_SLOTS_RST;
        shadow_plan.lcl_bytes   = SLOT_BYTES_RST;
        shadow_plan.len_cap     = PAYLOAD_MAX_RST;
        shadow_plan.phase       = PHASE_NONE;
        shadow_plan.tx_head     = '0;
        shadow_plan.tx_tail     = '0;
        shadow_plan.rx_head     = '0;
        shadow_plan.rx_credited = '0;
        shadow_plan.peer_slots  = 17'd1;
        shadow_plan.peer_bytes  = '0;
        shadow_live = shadow_plan;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset configuration leaves the ring disabled: every kind falls
        // back or is dropped.
        d = blank_item(KIND_SEND);
        void'(queue_item(d));
        d = blank_item(KIND_CHECK);
        d.observed_gen = 32'hFFFF_FFFF;
        void'(queue_item(d));
        d = blank_item(KIND_CREDIT);
        d.counter_value = '1;
        void'(queue_item(d));
        d = blank_item(KIND_CTRL);
        d.info_valid = 1'b1;
        d.remote_slots = RING_SLOTS_RST;
        d.remote_slot_bytes = SLOT_BYTES_RST;
        void'(queue_item(d));
        wait_drained();

        write_register(CFG_ENABLE, 32'd1);
        write_register(CFG_RING_SLOTS, 32'd4);
        write_register(CFG_SLOT_BYTES, 32'd65535);
        write_register(CFG_PAYLOAD_MAX, 32'd65535);

        // Control without valid info, then sends before any handshake: the
        // first one requests the ring, the second only falls back.
        d = blank_item(KIND_CTRL);
        d.remote_slots = 17'd4;
        d.remote_slot_bytes = 16'hFFFF;
        void'(queue_item(d));
        d = blank_item(KIND_SEND);
        d.length = 16'hFFFF;
        d.post_ok = 1'b1;
        void'(queue_item(d));
        void'(queue_item(d));
        d = blank_item(KIND_CHECK);
        d.observed_gen = 32'd1;
        void'(queue_item(d));
        // geometry mismatches, then a matching request that adopts the ring
        d = blank_item(KIND_CTRL);
        d.info_valid = 1'b1;
        d.remote_slots = 17'd5;
        d.remote_slot_bytes = 16'hFFFF;
        void'(queue_item(d));
        d.remote_slots = 17'd4;
        d.remote_slot_bytes = 16'd0;
        void'(queue_item(d));
        d.remote_slot_bytes = 16'hFFFF;
        d.ctrl_is_request = 1'b1;
        void'(queue_item(d));
        // remote write refused, then fill the ring, hit full, and refresh
        d = blank_item(KIND_SEND);
        void'(queue_item(d));
        d.post_ok = 1'b1;
        for (int k = 0; k < 5; k++) begin
            void'(queue_item(d));
        end
        d.counter_value = 64'd2;
        void'(queue_item(d));
        // deliver three slots; credit goes back only when the write is allowed
        d = blank_item(KIND_CHECK);
        d.observed_gen = 32'd1;
        void'(queue_item(d));
        void'(queue_item(d));
        d.post_ok = 1'b1;
        void'(queue_item(d));
        d.observed_gen = 32'hFFFF_FFFF;
        void'(queue_item(d));
        d = blank_item(KIND_CREDIT);
        d.counter_value = 64'd3;
        void'(queue_item(d));
        // re-adopt while ready, as an acknowledgment
        d = blank_item(KIND_CTRL);
        d.info_valid = 1'b1;
        d.remote_slots = 17'd4;
        d.remote_slot_bytes = 16'hFFFF;
        void'(queue_item(d));

        run_phase(1'b1, 17'd4, 16'd64, 16'd992, 37, 86, 110, 1'b0);
        run_phase(1'b1, 17'd1, 16'd65535, 16'd65535, 37, 86, 100, 1'b0);
        run_phase(1'b1, 17'd65536, 16'd1, 16'd0, 37, 86, 90, 1'b0);
        run_phase(1'b1, 17'd2, 16'd1024, 16'd512, 86, 37, 110, 1'b0);
        run_phase(1'b0, 17'd16, 16'd1024, 16'd992, 86, 37, 30, 1'b0);
        run_phase(1'b1, 17'd0, 16'd300, 16'd2000, 86, 37, 100, 1'b0);
        run_phase(1'b1, 17'd65537, 16'd7, 16'd100, 0, 0, 100, 1'b0);
        run_phase(1'b1, 17'd8, 16'd4096, 16'd65535, 0, 0, 150, 1'b1);

        // Last: a credit value far past the head locks the transmit side into
        // retry, since the tail never comes back down.
        d = blank_item(KIND_CREDIT);
        d.counter_value = 64'hFFFF_FFFF_FFFF_FF00;
        void'(queue_item(d));
        d = blank_item(KIND_SEND);
        d.post_ok = 1'b1;
        void'(queue_item(d));
        void'(queue_item(d));

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
